/* rtl/core/rotenc_pkg.sv */
// Package with shared types and constants for the two-channel rotary encoder block.
`timescale 1ns / 1ps

package rotenc_pkg;

    localparam int POS_W   = 32;
    localparam int STEP_W  = 4;
    localparam int TICK_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_WINDOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOCK   = 3'd5;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET   = 16'd5;
    localparam logic              ACCEL_EN_RESET   = 1'b1;
    localparam logic [TICK_W-1:0] ACCEL_WIN_RESET  = 16'd100;
    localparam logic [STEP_W-1:0] MAX_STEP_RESET   = 4'd10;
    localparam logic [TICK_W-1:0] IDLE_RESET       = 16'd500;
    localparam logic [TICK_W-1:0] PRESS_LOCK_RESET = 16'd50;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic              accel_enable;
        logic [TICK_W-1:0] accel_window_ticks;
        logic [STEP_W-1:0] max_step;
        logic [TICK_W-1:0] idle_ticks;
        logic [TICK_W-1:0] press_lockout_ticks;
    } cfg_t;

    typedef struct packed {
        logic pin_clk;
        logic pin_dt;
        logic pin_button;
    } pins_t;

endpackage

/* rtl/core/rotary_encoder_accel_debounce_top.sv */
// Top level of the two-channel rotary encoder with debounce, acceleration and press pulses.
`timescale 1ns / 1ps

// Each input request is one millisecond sample of the CLK, DT and button pins of
// channels A and B, taken when in_valid is high and in_stall is low. Each request
// produces exactly one result request carrying both positions, both step sizes and
// both press pulses, offered on out_valid and taken when out_stall is low.
// A request lands in an input register; once the result register is empty or being
// taken, the channel logic updates its state and the result register together, and
// out_valid rises with that update.
// Throughput is one request per cycle while out_stall is low, set by the single update of the channel state.
// When the receiver stalls, the result holds steady; the input register still
// takes one more request, and in_stall rises only once both registers are full.
// Configuration registers are written through cfg_write_en, cfg_index and
// cfg_data, and should be changed only while no request is in flight.
// Reset empties both pipeline registers, zeroes positions, steps and elapsed
// counters, treats CLK and button as high, and loads the default register values.
module rotary_encoder_accel_debounce_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [rotenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rotenc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 clk_a,
    input  logic                                 dt_a,
    input  logic                                 button_a,
    input  logic                                 clk_b,
    input  logic                                 dt_b,
    input  logic                                 button_b,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rotenc_pkg::POS_W-1:0]  position_a,
    output logic signed [rotenc_pkg::POS_W-1:0]  position_b,
    output logic [rotenc_pkg::STEP_W-1:0]        step_a,
    output logic [rotenc_pkg::STEP_W-1:0]        step_b,
    output logic                                 press_a,
    output logic                                 press_b
);

    rotenc_pkg::cfg_t  cfg;
    rotenc_pkg::pins_t pins_a_reg;
    rotenc_pkg::pins_t pins_b_reg;
    logic              in_vld_reg;
    logic              in_vld_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic              advance;
    logic              in_take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next  = in_take || (in_vld_reg && !advance);
        out_vld_next = advance || (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pins_a_reg <= '{pin_clk: clk_a, pin_dt: dt_a, pin_button: button_a};
            pins_b_reg <= '{pin_clk: clk_b, pin_dt: dt_b, pin_button: button_b};
        end
    end

    rotenc_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    rotenc_chan u_chan_a
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .pins     (pins_a_reg),
        .cfg      (cfg),
        .position (position_a),
        .step     (step_a),
        .press    (press_a)
    );

    rotenc_chan u_chan_b
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .pins     (pins_b_reg),
        .cfg      (cfg),
        .position (position_b),
        .step     (step_b),
        .press    (press_b)
    );

    assign out_valid = out_vld_reg;

    a_advance_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("Result register not valid after a channel update.");

    a_hold_without_advance : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(position_a) && $stable(position_b) &&
                      $stable(step_a) && $stable(step_b)))
        else $error("Channel state changed without a channel update.");

    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !advance)
        else $error("Channel update overwrote a result still waiting.");

endmodule

/* rtl/core/rotenc_cfg_regs.sv */
// Configuration register file written through the plain write port.
`timescale 1ns / 1ps

module rotenc_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [rotenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rotenc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rotenc_pkg::cfg_t                     cfg
);

    rotenc_pkg::cfg_t cfg_reg;
    rotenc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                rotenc_pkg::CFG_DEBOUNCE:     cfg_next.debounce_ticks = cfg_data;
                rotenc_pkg::CFG_ACCEL_ENABLE: cfg_next.accel_enable = cfg_data[0];
                rotenc_pkg::CFG_ACCEL_WINDOW: cfg_next.accel_window_ticks = cfg_data;
                rotenc_pkg::CFG_MAX_STEP:
                    cfg_next.max_step = cfg_data[rotenc_pkg::STEP_W-1:0];
                rotenc_pkg::CFG_IDLE:         cfg_next.idle_ticks = cfg_data;
                rotenc_pkg::CFG_PRESS_LOCK:   cfg_next.press_lockout_ticks = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks      <= rotenc_pkg::DEBOUNCE_RESET;
            cfg_reg.accel_enable        <= rotenc_pkg::ACCEL_EN_RESET;
            cfg_reg.accel_window_ticks  <= rotenc_pkg::ACCEL_WIN_RESET;
            cfg_reg.max_step            <= rotenc_pkg::MAX_STEP_RESET;
            cfg_reg.idle_ticks          <= rotenc_pkg::IDLE_RESET;
            cfg_reg.press_lockout_ticks <= rotenc_pkg::PRESS_LOCK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/rotenc_chan.sv */
// One encoder channel: edge debounce, step acceleration, position, idle and press logic.
`timescale 1ns / 1ps

module rotenc_chan
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  rotenc_pkg::pins_t                    pins,
    input  rotenc_pkg::cfg_t                     cfg,
    output logic signed [rotenc_pkg::POS_W-1:0]  position,
    output logic [rotenc_pkg::STEP_W-1:0]        step,
    output logic                                 press
);

    logic                                prev_clk_reg;
    logic                                prev_button_reg;
    logic [rotenc_pkg::POS_W-1:0]        position_reg;
    logic [rotenc_pkg::STEP_W-1:0]       step_reg;
    logic [rotenc_pkg::TICK_W-1:0]       since_edge_reg;
    logic [rotenc_pkg::TICK_W-1:0]       since_press_reg;
    logic                                press_reg;

    logic [rotenc_pkg::POS_W-1:0]        position_next;
    logic [rotenc_pkg::STEP_W-1:0]       step_next;
    logic [rotenc_pkg::TICK_W-1:0]       since_edge_next;
    logic [rotenc_pkg::TICK_W-1:0]       since_press_next;
    logic                                press_next;

    logic [rotenc_pkg::TICK_W-1:0]       edge_tick;
    logic [rotenc_pkg::TICK_W-1:0]       press_tick;
    logic [rotenc_pkg::STEP_W:0]         step_inc;
    logic [rotenc_pkg::STEP_W-1:0]       step_edge;
    logic [rotenc_pkg::POS_W-1:0]        amount;
    logic                                edge_hit;

    always_comb
    begin
        edge_tick  = (&since_edge_reg) ? since_edge_reg : since_edge_reg + 1'b1;
        press_tick = (&since_press_reg) ? since_press_reg : since_press_reg + 1'b1;

        edge_hit = prev_clk_reg && !pins.pin_clk && (edge_tick >= cfg.debounce_ticks);

        step_inc = {1'b0, step_reg} + 1'b1;
        if (edge_tick < cfg.accel_window_ticks)
        begin
            step_edge = (step_inc < {1'b0, cfg.max_step}) ?
                        step_inc[rotenc_pkg::STEP_W-1:0] : cfg.max_step;
        end
        else
        begin
            step_edge = rotenc_pkg::STEP_W'(1);
        end

        step_next       = step_reg;
        amount          = rotenc_pkg::POS_W'(1);
        position_next   = position_reg;
        since_edge_next = edge_tick;
        if (edge_hit)
        begin
            if (cfg.accel_enable)
            begin
                step_next = step_edge;
                amount    = rotenc_pkg::POS_W'(step_edge);
            end
            position_next   = pins.pin_dt ? position_reg + amount : position_reg - amount;
            since_edge_next = '0;
        end

        press_next       = !pins.pin_button && prev_button_reg &&
                           (press_tick > cfg.press_lockout_ticks);
        since_press_next = press_next ? '0 : press_tick;

        if (since_edge_next > cfg.idle_ticks)
        begin
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg    <= 1'b1;
            prev_button_reg <= 1'b1;
            position_reg    <= '0;
            step_reg        <= '0;
            since_edge_reg  <= '0;
            since_press_reg <= '0;
            press_reg       <= 1'b0;
        end
        else if (advance)
        begin
            prev_clk_reg    <= pins.pin_clk;
            prev_button_reg <= pins.pin_button;
            position_reg    <= position_next;
            step_reg        <= step_next;
            since_edge_reg  <= since_edge_next;
            since_press_reg <= since_press_next;
            press_reg       <= press_next;
        end
    end

    assign position = position_reg;
    assign step     = step_reg;
    assign press    = press_reg;

endmodule
